// ===== hw/rtl/apbs_pkg.sv =====
`timescale 1ns / 1ps

package apbs_pkg;

	// configuration port
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;
	localparam logic REG_COEFF = 1'b0;

	// sequencer program
	localparam int STEP_BITS = 3;
	typedef logic [STEP_BITS-1:0] step_t;

	localparam step_t STEP_IDLE = 3'd0;
	localparam step_t STEP_LP1_MUL = 3'd1;
	localparam step_t STEP_LP1_ACC = 3'd2;
	localparam step_t STEP_AP_ACC = 3'd3;
	localparam step_t STEP_LP2_ACC = 3'd4;
	localparam step_t STEP_LAST = 3'd5;

	typedef enum logic [1:0] {
		ASEL_X_Z1,
		ASEL_Y1_Z2,
		ASEL_X,
		ASEL_A
	} asel_t;

	typedef enum logic {
		BSEL_G2,
		BSEL_C
	} bsel_t;

	// rounding offset folded into the multiply: low-pass drops F+1 bits, all-pass F
	typedef enum logic {
		RND_LP,
		RND_AP
	} rsel_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_LP1,
		ACC_AP_A,
		ACC_LP2,
		ACC_AP_Z
	} acc_t;

	typedef enum logic {
		COND_NEXT,
		COND_TAKE
	} cond_t;

	typedef struct packed {
		logic mul;
		asel_t a_sel;
		bsel_t b_sel;
		rsel_t r_sel;
		acc_t acc;
		logic emit;
		logic take;
		cond_t cond;
		step_t go;
		step_t alt;
	} ctl_t;

	// control store, one word per step
	function automatic ctl_t ucode(input step_t step);
		ctl_t w;
		w = '{mul: 1'b0, a_sel: ASEL_X, b_sel: BSEL_C, r_sel: RND_AP, acc: ACC_NONE,
			emit: 1'b0, take: 1'b0, cond: COND_TAKE, go: STEP_IDLE, alt: STEP_IDLE};
		unique case (step)
			STEP_IDLE: begin
				w.take = 1'b1;
				w.cond = COND_TAKE;
				w.go = STEP_LP1_MUL;
				w.alt = STEP_IDLE;
			end
			STEP_LP1_MUL: begin
				w.mul = 1'b1;
				w.a_sel = ASEL_X_Z1;
				w.b_sel = BSEL_G2;
				w.r_sel = RND_LP;
				w.cond = COND_NEXT;
			end
			STEP_LP1_ACC: begin
				w.mul = 1'b1;
				w.a_sel = ASEL_X;
				w.b_sel = BSEL_C;
				w.r_sel = RND_AP;
				w.acc = ACC_LP1;
				w.cond = COND_NEXT;
			end
			STEP_AP_ACC: begin
				w.mul = 1'b1;
				w.a_sel = ASEL_Y1_Z2;
				w.b_sel = BSEL_G2;
				w.r_sel = RND_LP;
				w.acc = ACC_AP_A;
				w.cond = COND_NEXT;
			end
			STEP_LP2_ACC: begin
				w.mul = 1'b1;
				w.a_sel = ASEL_A;
				w.b_sel = BSEL_C;
				w.r_sel = RND_AP;
				w.acc = ACC_LP2;
				w.cond = COND_NEXT;
			end
			STEP_LAST: begin
				w.acc = ACC_AP_Z;
				w.emit = 1'b1;
				w.take = 1'b1;
				w.cond = COND_TAKE;
				w.go = STEP_LP1_MUL;
				w.alt = STEP_IDLE;
			end
			default: begin
				w.cond = COND_TAKE;
				w.go = STEP_IDLE;
				w.alt = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/allpass_band_splitter.sv =====
`timescale 1ns / 1ps

// Complementary first-order crossover: each sample yields one low band sample (two cascaded
// one-pole low-pass sections) and one high band sample (first-order all-pass minus low band),
// both saturated to SAMPLE_BITS. A six-step microprogram drives one multiply-accumulate unit
// followed by one accumulate/saturate stage; the four multiplies of a sample are issued one
// per cycle, each result folded into state the cycle after. For back-to-back samples the next
// sample is taken in the last step of the current one; from idle the sample is taken in the
// idle step, and the result is registered in the last step. The result register frees the input
// side, but the last step holds while an earlier result is still not taken. Writing crossover_coeff
// (byte address 0) clears the three filter states; write only while the block is idle.
module allpass_band_splitter #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEFF_FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [apbs_pkg::ADDR_BITS-1:0] paddr,
	input logic [apbs_pkg::DATA_BITS-1:0] pwdata,
	output logic [apbs_pkg::DATA_BITS-1:0] prdata,
	output logic pready,
	input logic item_valid,
	output logic item_ready,
	input logic signed [SAMPLE_BITS-1:0] sample,
	input logic frame_end,
	output logic result_valid,
	input logic result_ready,
	output logic signed [SAMPLE_BITS-1:0] high_band,
	output logic signed [SAMPLE_BITS-1:0] low_band,
	output logic frame_end_out
);
	import apbs_pkg::*;

	localparam int F = COEFF_FRAC_BITS;
	localparam int CW = COEFF_FRAC_BITS + 1;
	localparam int SW = SAMPLE_BITS + 4;
	localparam int AW = SW + 1;
	localparam int BW = COEFF_FRAC_BITS + 2;
	localparam int PW = AW + BW;
	localparam int DW = SW + 3;
	localparam int EW = SW + 4;

	// clamp to state width
	function automatic logic signed [SW-1:0] sat_st(input logic signed [EW-1:0] v);
		logic [EW-SW:0] top;
		top = v[EW-1:SW-1];
		if ((&top) || !(|top))
			return v[SW-1:0];
		return v[EW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
	endfunction

	// clamp to sample width
	function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [SW:0] v);
		logic [SW-SAMPLE_BITS+1:0] top;
		top = v[SW:SAMPLE_BITS-1];
		if ((&top) || !(|top))
			return v[SAMPLE_BITS-1:0];
		return v[SW] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	endfunction

	step_t pc_q;
	ctl_t ctl;
	logic hold;
	logic take_item;
	logic cfg_wr;

	logic signed [CW-1:0] coeff_q;
	logic signed [BW-1:0] g2_q;
	logic signed [SW-1:0] z1_q;
	logic signed [SW-1:0] z2_q;
	logic signed [SW-1:0] za_q;
	logic signed [SW-1:0] y1_q;
	logic signed [SW-1:0] y2_q;
	logic signed [SW-1:0] a_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic fe_q;
	logic signed [PW-1:0] prod_q;
	logic out_valid_q;
	logic signed [SAMPLE_BITS-1:0] high_q;
	logic signed [SAMPLE_BITS-1:0] low_q;
	logic fe_out_q;

	logic signed [AW-1:0] op_a;
	logic signed [BW-1:0] op_b;
	logic signed [PW-1:0] rnd_v;
	logic signed [PW-1:0] mac_v;
	logic signed [PW-1:0] sh_lp;
	logic signed [PW-1:0] sh_ap;
	logic signed [DW-1:0] d_lp;
	logic signed [DW-1:0] d_ap;
	logic signed [SW-1:0] y_new;
	logic signed [SW-1:0] z_new;
	logic signed [SW-1:0] z_sel;
	logic signed [SW-1:0] a_new;
	logic signed [SW-1:0] za_new;

	// control word and handshakes
	assign ctl = ucode(pc_q);
	assign hold = ctl.emit && out_valid_q && !result_ready;
	assign item_ready = ctl.take && !hold;
	assign take_item = item_valid && item_ready;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_COEFF);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_COEFF) ?
		{{(DATA_BITS-CW){coeff_q[CW-1]}}, coeff_q} : '0;

	// multiplier operands
	always_comb begin
		unique case (ctl.a_sel)
			ASEL_X_Z1: op_a = AW'(x_q) - AW'(z1_q);
			ASEL_Y1_Z2: op_a = AW'(y1_q) - AW'(z2_q);
			ASEL_X: op_a = AW'(x_q);
			ASEL_A: op_a = AW'(a_q);
			default: op_a = AW'(x_q);
		endcase
		unique case (ctl.b_sel)
			BSEL_G2: op_b = g2_q;
			BSEL_C: op_b = BW'(coeff_q);
			default: op_b = BW'(coeff_q);
		endcase
		rnd_v = (ctl.r_sel == RND_LP) ? (PW'(1) <<< F) : (PW'(1) <<< (F - 1));
		mac_v = op_a * op_b + rnd_v;
	end

	// accumulate and saturate
	always_comb begin
		sh_lp = prod_q >>> (F + 1);
		sh_ap = prod_q >>> F;
		d_lp = DW'(sh_lp);
		d_ap = DW'(sh_ap);
		z_sel = (ctl.acc == ACC_LP2) ? z2_q : z1_q;
		y_new = sat_st(EW'(z_sel) + EW'(d_lp));
		z_new = sat_st(EW'(y_new) + EW'(d_lp));
		a_new = sat_st(EW'(d_ap) + EW'(za_q));
		za_new = sat_st(EW'(x_q) - EW'(d_ap));
	end

	// sequencer and result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (!hold) begin
				unique case (ctl.cond)
					COND_NEXT: pc_q <= step_t'(pc_q + 1'b1);
					COND_TAKE: pc_q <= take_item ? ctl.go : ctl.alt;
					default: pc_q <= STEP_IDLE;
				endcase
			end
			if (ctl.emit && !hold)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	// coefficient and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
			g2_q <= BW'(1) <<< F;
			z1_q <= '0;
			z2_q <= '0;
			za_q <= '0;
		end else if (cfg_wr) begin
			coeff_q <= pwdata[CW-1:0];
			g2_q <= BW'($signed(pwdata[CW-1:0])) + (BW'(1) <<< F);
			z1_q <= '0;
			z2_q <= '0;
			za_q <= '0;
		end else if (!hold) begin
			unique case (ctl.acc)
				ACC_LP1: z1_q <= z_new;
				ACC_LP2: z2_q <= z_new;
				ACC_AP_Z: za_q <= za_new;
				ACC_AP_A, ACC_NONE: ;
				default: ;
			endcase
		end
	end

	// datapath payload registers
	always_ff @(posedge clk) begin
		if (take_item) begin
			x_q <= sample;
			fe_q <= frame_end;
		end
		if (ctl.mul && !hold)
			prod_q <= mac_v;
		if (!hold) begin
			unique case (ctl.acc)
				ACC_LP1: y1_q <= y_new;
				ACC_LP2: y2_q <= y_new;
				ACC_AP_A: a_q <= a_new;
				ACC_AP_Z, ACC_NONE: ;
				default: ;
			endcase
		end
		if (ctl.emit && !hold) begin
			low_q <= sat_out((SW + 1)'(y2_q));
			high_q <= sat_out((SW + 1)'(a_q) - (SW + 1)'(y2_q));
			fe_out_q <= fe_q;
		end
	end

	assign result_valid = out_valid_q;
	assign high_band = high_q;
	assign low_band = low_q;
	assign frame_end_out = fe_out_q;

	// samples enter only at the idle or last step
	a_take_step: assert property (@(posedge clk) disable iff (!arst_n)
		take_item |-> (pc_q == STEP_IDLE || pc_q == STEP_LAST))
		else $error("sample taken in the middle of a computation");

	// a full result register freezes the last step
	a_hold_step: assert property (@(posedge clk) disable iff (!arst_n)
		hold |=> (pc_q == STEP_LAST && $stable(za_q)))
		else $error("sequencer advanced while result register was full");

	// a coefficient write clears the three filter states
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (z1_q == '0 && z2_q == '0 && za_q == '0))
		else $error("filter state not cleared by coefficient write");

	// a new result appears only after the last step
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(pc_q) == STEP_LAST))
		else $error("result valid raised outside the last step");

endmodule
